@@ src/htd_pkg.sv @@
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants for the Huffman tree decoder
// Field widths, operation codes and the result record carried to the output.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  localparam int SYM_W  = 8;   // symbol byte
  localparam int WORD_W = 12;  // code_word field
  localparam int LEN_W  = 4;   // code_len field

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [SYM_W-1:0] SYM_EMPTY = '0;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             path_error;
  } htd_result_t;

endpackage

`default_nettype wire

@@ src/huffman_tree_decoder.sv @@
// ----------------------------------------------------------------------------
// huffman_tree_decoder: bit-serial Huffman decoder over a heap-indexed tree
//
// Input channel (in_valid/in_ready): op selects a load or a decode transfer.
//   Load: symbol_in goes to index (1 << code_len) | code_word[code_len-1:0].
//     Length zero or above MAX_CODE_LEN is ignored; symbol zero empties a leaf.
//   Decode: one stream bit moves the walk from index k to 2k+code_bit.
// Output channel (out_valid/out_ready): one transfer per leaf reached
//   (symbol_out, path_error = 0) or per walk that hits maximum depth on an
//   empty entry (symbol_out = 0, path_error = 1). Either returns to the root.
// Throughput: one item per cycle while in_ready is high, loads and decodes
//   mixed freely. The tree memory returns its entry in the cycle after a
//   decode is taken; that data selects the walk index used by the next bit
//   in that same cycle. The tree read data is registered in the RAM, and the
//   result then passes through the output buffer before out_valid rises.
// Reset: a clearing pass zeroes all 2^(MAX_CODE_LEN+1) tree entries (8192 at
//   the default), one entry per cycle; in_ready is low meanwhile.
// Stalls: results sit in a two-entry buffer; once clearing ends, in_ready
//   drops only when it could overflow, so no result is lost on a low out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder #(
  parameter int MAX_CODE_LEN = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       op,
  input  wire logic                       code_bit,
  input  wire logic [htd_pkg::WORD_W-1:0] code_word,
  input  wire logic [htd_pkg::LEN_W-1:0]  code_len,
  input  wire logic [htd_pkg::SYM_W-1:0]  symbol_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [htd_pkg::SYM_W-1:0]       symbol_out,
  output logic                            path_error
);

  localparam int IDX_W     = MAX_CODE_LEN + 1;
  localparam int TREE_SIZE = 1 << IDX_W;
  localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

  // clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  // walk state
  logic [IDX_W-1:0] walk;
  logic [IDX_W-1:0] cur_walk;
  logic [IDX_W-1:0] dec_idx;

  // lookup stage: decode whose tree read is in flight
  logic             look_valid;
  logic [IDX_W-1:0] look_idx;

  // handshake
  logic in_fire;
  logic load_fire;
  logic dec_fire;
  logic load_ok;
  logic out_pop;

  // load index
  logic [IDX_W-1:0]              load_idx;
  logic [IDX_W+htd_pkg::WORD_W-1:0] word_ext;

  // memory ports
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [htd_pkg::SYM_W-1:0] mem_wdata;
  logic [htd_pkg::SYM_W-1:0] mem_rdata;

  // result path
  logic                 hit;
  logic                 depth_err;
  logic                 res_push;
  htd_pkg::htd_result_t res;
  htd_pkg::htd_result_t out_data;
  logic [1:0]           fifo_count;
  logic [2:0]           fill_next;

  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (op == htd_pkg::OP_LOAD);
  assign dec_fire  = in_fire && (op == htd_pkg::OP_DECODE);
  assign out_pop   = out_valid && out_ready;

  // Leaf of a load: bit code_len set, code bits below it, nothing above.
  assign word_ext = {{IDX_W{1'b0}}, code_word};

  always_comb begin
    load_ok = (code_len != '0) && (int'(code_len) <= MAX_CODE_LEN);
    for (int i = 0; i < IDX_W; i++) begin
      load_idx[i] = (int'(code_len) == i) || ((i < int'(code_len)) && word_ext[i]);
    end
  end

  // Lookup result: a nonzero entry is a leaf; an empty entry at full depth
  // is a broken path. Both send the walk back to the root.
  assign hit       = look_valid && (mem_rdata != htd_pkg::SYM_EMPTY);
  assign depth_err = look_valid && !hit && look_idx[IDX_W-1];
  assign res_push  = hit || depth_err;

  always_comb begin
    res.symbol     = hit ? mem_rdata : htd_pkg::SYM_EMPTY;
    res.path_error = depth_err;
  end

  // Walk forwarding: the bit taken this cycle follows the lookup resolving now.
  always_comb begin
    if (res_push) begin
      cur_walk = ROOT;
    end else if (look_valid) begin
      cur_walk = look_idx;
    end else begin
      cur_walk = walk;
    end
  end

  assign dec_idx = {cur_walk[IDX_W-2:0], code_bit};

  // Buffer level after this cycle plus the result the next cycle may push
  // must stay within two entries.
  assign fill_next = {1'b0, fifo_count} + {2'b00, res_push} - {2'b00, out_pop};
  assign in_ready  = !clearing && (fill_next <= 3'd1);

  // Tree memory write port: clearing pass, then loads.
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = htd_pkg::SYM_EMPTY;
    end else begin
      mem_we    = load_fire && load_ok;
      mem_waddr = load_idx;
      mem_wdata = symbol_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      walk       <= ROOT;
      look_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(TREE_SIZE - 1)) begin
          clearing <= 1'b0;
        end
      end
      walk       <= cur_walk;
      look_valid <= dec_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire) begin
      look_idx <= dec_idx;
    end
  end

  htd_ram #(
    .WIDTH (htd_pkg::SYM_W),
    .DEPTH (TREE_SIZE)
  ) u_tree (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (dec_fire),
    .raddr (dec_idx),
    .rdata (mem_rdata)
  );

  htd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign symbol_out = out_data.symbol;
  assign path_error = out_data.path_error;

endmodule

`default_nettype wire

@@ src/htd_ram.sv @@
// ----------------------------------------------------------------------------
// htd_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/htd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// htd_out_fifo: two-entry result buffer
// Decouples the tree walk from output stalls; reports its fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire htd_pkg::htd_result_t push_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output htd_pkg::htd_result_t      out_data,
  output logic [1:0]                count
);

  htd_pkg::htd_result_t entry [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic                 pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ bench/htd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htd_checker: prediction and comparison for the Huffman tree decoder
// Keeps its own copy of the code tree and walk position, predicts one result
// per decode transfer that ends a walk, and compares each output transfer
// with the oldest predicted result. Hands out a failure count and the number
// of results still outstanding.
// ----------------------------------------------------------------------------
module htd_checker #(
  parameter int MAX_LEN = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic                       op,
  input  wire logic                       code_bit,
  input  wire logic [htd_pkg::WORD_W-1:0] code_word,
  input  wire logic [htd_pkg::LEN_W-1:0]  code_len,
  input  wire logic [htd_pkg::SYM_W-1:0]  symbol_in,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [htd_pkg::SYM_W-1:0]  symbol_out,
  input  wire logic                       path_error,
  output int                              fail_count,
  output int                              pending
);

  localparam int TREE_DEPTH = 1 << (MAX_LEN + 1);
  localparam int LEAF_FLOOR = 1 << MAX_LEN;  // first index at maximum depth

  logic [htd_pkg::SYM_W-1:0] tree_copy [TREE_DEPTH];
  int                        walk_pos;
  htd_pkg::htd_result_t      decoded_q [$];

  always @(posedge clk) begin
    htd_pkg::htd_result_t want;
    htd_pkg::htd_result_t got;
    int                   slot;
    int                   nxt;
    if (rst) begin
      for (int i = 0; i < TREE_DEPTH; i++) tree_copy[i] = htd_pkg::SYM_EMPTY;
      walk_pos   = 1;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (op == htd_pkg::OP_LOAD) begin
          // lengths of zero or past the tree depth leave the table alone
          if (code_len != 0 && int'(code_len) <= MAX_LEN) begin
            slot = (1 << code_len) | (int'(code_word) & ((1 << code_len) - 1));
            tree_copy[slot] = symbol_in;
          end
        end else begin
          nxt = ((walk_pos << 1) | int'(code_bit)) & (TREE_DEPTH - 1);
          if (tree_copy[nxt] != htd_pkg::SYM_EMPTY) begin
            want.symbol     = tree_copy[nxt];
            want.path_error = 1'b0;
            decoded_q.push_back(want);
            walk_pos = 1;
          end else if (nxt >= LEAF_FLOOR) begin
            want.symbol     = htd_pkg::SYM_EMPTY;
            want.path_error = 1'b1;
            decoded_q.push_back(want);
            walk_pos = 1;
          end else begin
            walk_pos = nxt;
          end
        end
      end
      if (out_valid && out_ready) begin
        got.symbol     = symbol_out;
        got.path_error = path_error;
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: symbol %0d path_error %0b",
                     got.symbol, got.path_error);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected symbol %0d path_error %0b,%s%0d %s%0b",
                       want.symbol, want.path_error, " got symbol ", got.symbol,
                       "path_error ", got.path_error);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

@@ bench/tb_huffman_tree_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_decoder: stimulus and verdict for the Huffman tree decoder
// A short directed run hits the field extremes, ignored lengths, dropped
// code word bits, leaf clearing and a maximum-depth path error. Then random
// phases each wipe the previous table, load a prefix code table, stream
// encoded symbols through it with some noise and broken codes. Sender works
// in bursts, receiver stalls in patterns; htd_checker does all the checking.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder;

  localparam int MAX_LEN      = 12;
  localparam int TARGET_ITEMS = 1200;
  localparam int MAX_LEAVES   = 16;
  localparam int DRAIN_CYCLES = 20;   // extra wait after the last result drains

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic                       op        = htd_pkg::OP_LOAD;
  logic                       code_bit  = 1'b0;
  logic [htd_pkg::WORD_W-1:0] code_word = '0;
  logic [htd_pkg::LEN_W-1:0]  code_len  = '0;
  logic [htd_pkg::SYM_W-1:0]  symbol_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [htd_pkg::SYM_W-1:0]  symbol_out;
  logic                       path_error;

  int fail_count;
  int pending;

  // sender burst state and count of transfers that touch the decoder
  int burst_left = 0;
  int items_sent = 0;

  // receiver stall pattern
  int rdy_mode = 0;
  int rdy_left = 0;

  // prefix code of the current phase
  int                        leaf_len  [MAX_LEAVES];
  int                        leaf_code [MAX_LEAVES];
  logic [htd_pkg::SYM_W-1:0] leaf_sym  [MAX_LEAVES];
  int                        n_leaves;

  // every entry written since the last wipe, so it can be emptied again
  int loaded_len  [$];
  int loaded_word [$];

  huffman_tree_decoder #(
    .MAX_CODE_LEN(MAX_LEN)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .code_bit  (code_bit),
    .code_word (code_word),
    .code_len  (code_len),
    .symbol_in (symbol_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol_out(symbol_out),
    .path_error(path_error)
  );

  htd_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .code_bit  (code_bit),
    .code_word (code_word),
    .code_len  (code_len),
    .symbol_in (symbol_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol_out(symbol_out),
    .path_error(path_error),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: picks a stall pattern, holds it for a random stretch.
  // Mode 0 never stalls, mode 2 is ready only now and then.
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 200);
    end
    rdy_left--;
    case (rdy_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // One input transfer. Entered and left at a falling edge; valid stays up
  // between back-to-back items of a burst and drops only for a gap.
  task automatic send_item(input logic f_op, input logic f_bit, input int f_word,
                           input int f_len, input int f_sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid  <= 1'b1;
    op        <= f_op;
    code_bit  <= f_bit;
    code_word <= htd_pkg::WORD_W'(f_word);
    code_len  <= htd_pkg::LEN_W'(f_len);
    symbol_in <= htd_pkg::SYM_W'(f_sym);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (f_op == htd_pkg::OP_DECODE || (f_len >= 1 && f_len <= MAX_LEN)) items_sent++;
    @(negedge clk);
  endtask

  // Table write; bits of the word above the code length get random junk,
  // which the decoder has to drop.
  task automatic load_entry(input int len, input int code, input int sym);
    int word;
    word = ((code & ((1 << len) - 1)) | ($urandom() << len))
           & ((1 << htd_pkg::WORD_W) - 1);
    if (len >= 1 && len <= MAX_LEN) begin
      loaded_len.push_back(len);
      loaded_word.push_back(word);
    end
    send_item(htd_pkg::OP_LOAD, 1'($urandom_range(0, 1)), word, len, sym);
  endtask

  // Stream bit; the load-only fields carry random values that must not matter.
  task automatic decode_bit(input logic b);
    send_item(htd_pkg::OP_DECODE, b, $urandom_range(0, 4095), $urandom_range(0, 15),
              $urandom_range(0, 255));
  endtask

  // Send the first n bits of a code, most significant first.
  task automatic send_code(input int len, input int code, input int n);
    for (int b = len - 1; b >= len - n; b--) decode_bit(1'((code >> b) & 1));
  endtask

  // Random prefix code by repeated leaf splitting. Skewed mode always splits
  // the newest leaf, which drives codes down to maximum depth.
  task automatic build_code();
    int target;
    int pick;
    int guard;
    bit skew;
    target       = $urandom_range(2, MAX_LEAVES);
    skew         = ($urandom_range(0, 3) == 0);
    leaf_len[0]  = 1;
    leaf_code[0] = 0;
    leaf_len[1]  = 1;
    leaf_code[1] = 1;
    n_leaves     = 2;
    guard        = 0;
    while (n_leaves < target && guard < 200) begin
      pick = skew ? n_leaves - 1 : $urandom_range(0, n_leaves - 1);
      if (leaf_len[pick] < MAX_LEN) begin
        leaf_len[pick]++;
        leaf_code[pick]     = leaf_code[pick] << 1;
        leaf_len[n_leaves]  = leaf_len[pick];
        leaf_code[n_leaves] = leaf_code[pick] | 1;
        n_leaves++;
      end
      guard++;
    end
    for (int i = 0; i < n_leaves; i++) leaf_sym[i] = $urandom_range(1, 255);
  endtask

  // Empty every entry written so far by loading the null symbol.
  task automatic wipe_table();
    for (int i = 0; i < loaded_len.size(); i++)
      send_item(htd_pkg::OP_LOAD, 1'($urandom_range(0, 1)), loaded_word[i],
                loaded_len[i], htd_pkg::SYM_EMPTY);
    loaded_len.delete();
    loaded_word.delete();
  endtask

  initial begin
    int drop;
    int n_syms;
    int pick;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // ---------------- directed ----------------
    // loads with lengths the tree cannot hold: all ignored
    send_item(htd_pkg::OP_LOAD, 1'b0, 'hFFF, 0, 'hAA);
    send_item(htd_pkg::OP_LOAD, 1'b1, 'h000, MAX_LEN + 1, 'h55);
    send_item(htd_pkg::OP_LOAD, 1'b0, 'hFFF, 15, 'hFF);
    // "0" -> 255 with junk above bit 0, "10" -> 0x80, all ones at full depth -> 1
    load_entry(1, 0, 255);
    load_entry(2, 2, 'h80);
    load_entry(MAX_LEN, 'hFFF, 1);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    // eleven ones then a zero: empty all the way down, so a path error
    send_code(MAX_LEN, 'hFFE, MAX_LEN);
    // null symbol empties "0"; decoding it now just walks on
    load_entry(1, 0, htd_pkg::SYM_EMPTY);
    decode_bit(1'b0);

    // ---------------- random phases ----------------
    while (items_sent < TARGET_ITEMS) begin
      wipe_table();
      build_code();
      // sometimes leave a leaf out so its code runs into empty subtree
      drop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_leaves - 1) : -1;
      for (int i = 0; i < n_leaves; i++)
        if (i != drop) load_entry(leaf_len[i], leaf_code[i], leaf_sym[i]);
      n_syms = $urandom_range(10, 40);
      for (int s = 0; s < n_syms; s++) begin
        pick = $urandom_range(0, n_leaves - 1);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: begin
              decode_bit(1'($urandom_range(0, 1)));
            end
            1: begin
              // stray write anywhere, any length, any symbol incl. null
              load_entry($urandom_range(0, 15), $urandom_range(0, 4095),
                         $urandom_range(0, 255));
            end
            default: begin
              // truncated code leaves the walk mid-tree
              send_code(leaf_len[pick], leaf_code[pick],
                        $urandom_range(0, leaf_len[pick] - 1));
            end
          endcase
        end else begin
          send_code(leaf_len[pick], leaf_code[pick], leaf_len[pick]);
        end
      end
      // hold the sender until every result of this phase has drained
      if (pending != 0) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: well beyond the reset clearing pass plus the slowest stalls.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
